@@ src/coin_pulse_decoder_counter_top_defines.svh @@
// assertion helpers for the top-level rtl file
`ifndef COIN_PULSE_DECODER_COUNTER_TOP_DEFINES_SVH
`define COIN_PULSE_DECODER_COUNTER_TOP_DEFINES_SVH

// same-cycle implication, disabled during reset
`define CPDC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("cpdc assertion failed");

// next-cycle implication, disabled during reset
`define CPDC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("cpdc assertion failed");

`endif

@@ src/cpdc_pkg.sv @@
package cpdc_pkg;

    localparam int COIN_TYPES_DEF = 7;
    localparam int IDX_W          = 5;
    localparam int NUM_MATCH      = 6;

    localparam int PULSE_W    = 6;
    localparam int DEBOUNCE_W = 10;
    localparam int END_W      = 12;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;
    localparam int TYPE_W     = 3;
    localparam int CENTS_W    = 8;
    localparam int COUNT_W    = 32;

    typedef enum logic [1:0] {
        KIND_TICK  = 2'd0,
        KIND_PULSE = 2'd1,
        KIND_CLEAR = 2'd2,
        KIND_READ  = 2'd3
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_P200     = 3'd0,
        CFG_P100     = 3'd1,
        CFG_P50      = 3'd2,
        CFG_P20      = 3'd3,
        CFG_P10      = 3'd4,
        CFG_P5       = 3'd5,
        CFG_DEBOUNCE = 3'd6,
        CFG_END      = 3'd7
    } t_cfg_idx;

    localparam logic [TYPE_W-1:0] TYPE_200     = 3'd0;
    localparam logic [TYPE_W-1:0] TYPE_100     = 3'd1;
    localparam logic [TYPE_W-1:0] TYPE_50      = 3'd2;
    localparam logic [TYPE_W-1:0] TYPE_20      = 3'd3;
    localparam logic [TYPE_W-1:0] TYPE_10      = 3'd4;
    localparam logic [TYPE_W-1:0] TYPE_5       = 3'd5;
    localparam logic [TYPE_W-1:0] TYPE_UNKNOWN = 3'd6;

    localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RST = 10'd20;
    localparam logic [END_W-1:0]      END_RST      = 12'd200;

    function automatic logic [PULSE_W-1:0] pulses_rst(input int idx);
        pulses_rst = PULSE_W'(idx + 1);
    endfunction

    function automatic logic [CENTS_W-1:0] cents_of(input logic [TYPE_W-1:0] t);
        case (t)
            TYPE_200: cents_of = 8'd200;
            TYPE_100: cents_of = 8'd100;
            TYPE_50:  cents_of = 8'd50;
            TYPE_20:  cents_of = 8'd20;
            TYPE_10:  cents_of = 8'd10;
            TYPE_5:   cents_of = 8'd5;
            default:  cents_of = 8'd0;
        endcase
    endfunction

endpackage

@@ src/coin_pulse_decoder_counter_top.sv @@
// coin pulse decoder and counter
// path: an input transaction passes the input register, then the result register
// throughput: one item per cycle unless i_stall holds the output; counters update on item advance
// reset: synchronous active-low i_rst_n clears all counters, both stages and loads
// the configuration defaults; no clearing pass, items accepted right after reset
`include "coin_pulse_decoder_counter_top_defines.svh"

module coin_pulse_decoder_counter_top #(
    parameter int COIN_TYPES = cpdc_pkg::COIN_TYPES_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic [1:0]                           i_kind,
    input  logic [cpdc_pkg::TYPE_W-1:0]          i_type_index,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic                                 o_coin_done,
    output logic [cpdc_pkg::TYPE_W-1:0]          o_coin_type,
    output logic [cpdc_pkg::CENTS_W-1:0]         o_coin_cents,
    output logic [cpdc_pkg::PULSE_W-1:0]         o_pulse_total,
    output logic [cpdc_pkg::COUNT_W-1:0]         o_type_count,
    output logic [cpdc_pkg::COUNT_W-1:0]         o_money_total,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [cpdc_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [cpdc_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    localparam int TW = (COIN_TYPES > 1) ? $clog2(COIN_TYPES) : 1;

    // configuration
    logic [cpdc_pkg::PULSE_W-1:0]    r_pulses [cpdc_pkg::NUM_MATCH];
    logic [cpdc_pkg::DEBOUNCE_W-1:0] r_debounce;
    logic [cpdc_pkg::END_W-1:0]      r_end;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < cpdc_pkg::NUM_MATCH; i++) begin
                r_pulses[i] <= cpdc_pkg::pulses_rst(i);
            end
            r_debounce <= cpdc_pkg::DEBOUNCE_RST;
            r_end      <= cpdc_pkg::END_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (cpdc_pkg::t_cfg_idx'(i_cfg_index))
                cpdc_pkg::CFG_DEBOUNCE: r_debounce <= i_cfg_data[cpdc_pkg::DEBOUNCE_W-1:0];
                cpdc_pkg::CFG_END:      r_end      <= i_cfg_data;
                default: r_pulses[i_cfg_index] <= i_cfg_data[cpdc_pkg::PULSE_W-1:0];
            endcase
        end
    end

    // input register
    logic                          r_in_valid;
    cpdc_pkg::t_kind               r_in_kind;
    logic [cpdc_pkg::TYPE_W-1:0]   r_in_tidx;
    logic                          advance;
    logic                          in_take;

    assign advance = r_in_valid && (!o_valid || !i_stall);
    assign o_stall = r_in_valid && !advance;
    assign in_take = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take || advance) begin
            r_in_valid <= in_take;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_kind <= cpdc_pkg::t_kind'(i_kind);
            r_in_tidx <= i_type_index;
        end
    end

    // decoder state
    logic [cpdc_pkg::END_W-1:0]   r_elapsed,     n_elapsed;
    logic [cpdc_pkg::PULSE_W-1:0] r_pulse_count, n_pulse_count;
    logic                         r_active,      n_active;
    logic [cpdc_pkg::COUNT_W-1:0] r_counts [COIN_TYPES];
    logic [cpdc_pkg::COUNT_W-1:0] r_money,       n_money;

    logic [cpdc_pkg::END_W:0]     next_elapsed;
    logic                         finish;
    logic [cpdc_pkg::TYPE_W-1:0]  match_type;
    logic [cpdc_pkg::CENTS_W-1:0] cents;
    logic [cpdc_pkg::TYPE_W-1:0]  sel_type;
    logic [cpdc_pkg::IDX_W-1:0]   sel_ext;
    logic                         sel_in_range;
    logic [cpdc_pkg::COUNT_W-1:0] sel_count;
    logic [cpdc_pkg::COUNT_W-1:0] inc_count;
    logic [cpdc_pkg::COUNT_W:0]   money_sum;
    logic                         count_write;
    logic                         count_clear;

    logic                         n_done;
    logic [cpdc_pkg::TYPE_W-1:0]  n_type;
    logic [cpdc_pkg::CENTS_W-1:0] n_cents;
    logic [cpdc_pkg::PULSE_W-1:0] n_ptotal;
    logic [cpdc_pkg::COUNT_W-1:0] n_tcount;

    // first match wins
    always_comb begin
        match_type = cpdc_pkg::TYPE_UNKNOWN;
        for (int i = cpdc_pkg::NUM_MATCH - 1; i >= 0; i--) begin
            if (r_pulses[i] == r_pulse_count) begin
                match_type = cpdc_pkg::TYPE_W'(i);
            end
        end
    end

    assign next_elapsed = {1'b0, r_elapsed} + 13'd1;
    assign finish       = r_active && (next_elapsed > {1'b0, r_end});
    assign cents        = cpdc_pkg::cents_of(match_type);

    assign sel_type     = (r_in_kind == cpdc_pkg::KIND_READ) ? r_in_tidx : match_type;
    assign sel_ext      = {2'b00, sel_type};
    assign sel_in_range = sel_ext < cpdc_pkg::IDX_W'(COIN_TYPES);
    assign sel_count    = sel_in_range ? r_counts[sel_ext[TW-1:0]] : '0;
    assign inc_count    = (&sel_count) ? sel_count : sel_count + 32'd1;
    assign money_sum    = {1'b0, r_money} + {25'd0, cents};

    always_comb begin
        n_elapsed     = r_elapsed;
        n_pulse_count = r_pulse_count;
        n_active      = r_active;
        n_money       = r_money;
        count_write   = 1'b0;
        count_clear   = 1'b0;
        n_done        = 1'b0;
        n_type        = '0;
        n_cents       = '0;
        n_ptotal      = '0;
        n_tcount      = '0;
        case (r_in_kind)
            cpdc_pkg::KIND_TICK: begin
                if (finish) begin
                    n_done        = 1'b1;
                    n_type        = match_type;
                    n_cents       = cents;
                    n_ptotal      = r_pulse_count;
                    count_write   = sel_in_range;
                    n_tcount      = sel_in_range ? inc_count : '0;
                    n_money       = money_sum[cpdc_pkg::COUNT_W] ? '1
                                  : money_sum[cpdc_pkg::COUNT_W-1:0];
                    n_pulse_count = '0;
                    n_elapsed     = '0;
                    n_active      = 1'b0;
                end else if (r_active) begin
                    n_elapsed = next_elapsed[cpdc_pkg::END_W-1:0];
                end
            end
            cpdc_pkg::KIND_PULSE: begin
                if (!r_active || (r_elapsed >= {2'b00, r_debounce})) begin
                    if (!(&r_pulse_count)) begin
                        n_pulse_count = r_pulse_count + 6'd1;
                    end
                    n_elapsed = '0;
                    n_active  = 1'b1;
                end
            end
            cpdc_pkg::KIND_CLEAR: begin
                count_clear = 1'b1;
                n_money     = '0;
            end
            cpdc_pkg::KIND_READ: begin
                n_tcount = sel_count;
            end
            default: begin
                n_tcount = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_elapsed     <= '0;
            r_pulse_count <= '0;
            r_active      <= 1'b0;
            r_money       <= '0;
            for (int i = 0; i < COIN_TYPES; i++) begin
                r_counts[i] <= '0;
            end
        end else if (advance) begin
            r_elapsed     <= n_elapsed;
            r_pulse_count <= n_pulse_count;
            r_active      <= n_active;
            r_money       <= n_money;
            if (count_clear) begin
                for (int i = 0; i < COIN_TYPES; i++) begin
                    r_counts[i] <= '0;
                end
            end else if (count_write) begin
                r_counts[sel_ext[TW-1:0]] <= inc_count;
            end
        end
    end

    // result register
    logic r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            o_coin_done   <= n_done;
            o_coin_type   <= n_type;
            o_coin_cents  <= n_cents;
            o_pulse_total <= n_ptotal;
            o_type_count  <= n_tcount;
            o_money_total <= n_money;
        end
    end

    assign o_valid = r_out_valid;

    `CPDC_ASSERT_NOW(a_idle_clean, !r_active, (r_pulse_count == '0) && (r_elapsed == '0))
    `CPDC_ASSERT_NOW(a_done_has_pulses, o_valid && o_coin_done, o_pulse_total != '0)
    `CPDC_ASSERT_NEXT(a_finish_goes_idle, advance && (r_in_kind == cpdc_pkg::KIND_TICK) && finish, !r_active)

endmodule

@@ test/tb_coin_pulse_decoder_counter_top.sv @@
`timescale 1ns / 100ps

typedef struct packed {
    logic                             coin_done;
    logic [cpdc_pkg::TYPE_W-1:0]      coin_type;
    logic [cpdc_pkg::CENTS_W-1:0]     coin_cents;
    logic [cpdc_pkg::PULSE_W-1:0]     pulse_total;
    logic [cpdc_pkg::COUNT_W-1:0]     type_count;
    logic [cpdc_pkg::COUNT_W-1:0]     money_total;
} t_coin_result;

class coin_tally_scoreboard;
    logic [cpdc_pkg::PULSE_W-1:0]    match_pulses[cpdc_pkg::NUM_MATCH];
    logic [cpdc_pkg::DEBOUNCE_W-1:0] debounce_ticks;
    logic [cpdc_pkg::END_W-1:0]      end_ticks;
    logic [cpdc_pkg::END_W-1:0]      elapsed;
    logic [cpdc_pkg::PULSE_W-1:0]    pulse_count;
    logic                            coin_active;
    logic [cpdc_pkg::COUNT_W-1:0]    type_counts[cpdc_pkg::COIN_TYPES_DEF];
    logic [cpdc_pkg::COUNT_W-1:0]    money_sum;
    t_coin_result                    expected_results[$];
    int                              checked;
    int                              failures;

    function new();
        foreach (match_pulses[i]) match_pulses[i] = cpdc_pkg::PULSE_W'(i + 1);
        debounce_ticks = cpdc_pkg::DEBOUNCE_RST;
        end_ticks      = cpdc_pkg::END_RST;
        elapsed        = '0;
        pulse_count    = '0;
        coin_active    = 1'b0;
        foreach (type_counts[i]) type_counts[i] = '0;
        money_sum      = '0;
        checked        = 0;
        failures       = 0;
    endfunction

    function void set_reg(input cpdc_pkg::t_cfg_idx idx,
                          input logic [cpdc_pkg::CFG_DATA_W-1:0] data);
        case (idx)
            cpdc_pkg::CFG_DEBOUNCE: debounce_ticks = data[cpdc_pkg::DEBOUNCE_W-1:0];
            cpdc_pkg::CFG_END:      end_ticks = data[cpdc_pkg::END_W-1:0];
            default:                match_pulses[idx] = data[cpdc_pkg::PULSE_W-1:0];
        endcase
    endfunction

    function logic [cpdc_pkg::COUNT_W-1:0] add_saturating(
        input logic [cpdc_pkg::COUNT_W-1:0] a,
        input logic [cpdc_pkg::COUNT_W-1:0] b);
        logic [cpdc_pkg::COUNT_W:0] sum;
        sum = a + b;
        return sum[cpdc_pkg::COUNT_W] ? '1 : sum[cpdc_pkg::COUNT_W-1:0];
    endfunction

    function logic [cpdc_pkg::CENTS_W-1:0] type_cents(input logic [cpdc_pkg::TYPE_W-1:0] t);
        case (t)
            cpdc_pkg::TYPE_200: return 8'd200;
            cpdc_pkg::TYPE_100: return 8'd100;
            cpdc_pkg::TYPE_50:  return 8'd50;
            cpdc_pkg::TYPE_20:  return 8'd20;
            cpdc_pkg::TYPE_10:  return 8'd10;
            cpdc_pkg::TYPE_5:   return 8'd5;
            default:            return 8'd0;
        endcase
    endfunction

    function void note_item(input cpdc_pkg::t_kind kind,
                            input logic [cpdc_pkg::TYPE_W-1:0] tidx);
        t_coin_result                r;
        logic [cpdc_pkg::END_W:0]    next_elapsed;
        logic [cpdc_pkg::TYPE_W-1:0] t;
        r = '0;
        case (kind)
            cpdc_pkg::KIND_TICK: begin
                if (coin_active) begin
                    next_elapsed = {1'b0, elapsed} + 1'b1;
                    if (next_elapsed > {1'b0, end_ticks}) begin
                        // first matching register wins
                        t = cpdc_pkg::TYPE_UNKNOWN;
                        for (int i = cpdc_pkg::NUM_MATCH - 1; i >= 0; i--) begin
                            if (match_pulses[i] == pulse_count) t = cpdc_pkg::TYPE_W'(i);
                        end
                        type_counts[t] = add_saturating(type_counts[t], 1);
                        money_sum      = add_saturating(money_sum,
                                                        cpdc_pkg::COUNT_W'(type_cents(t)));
                        r.coin_done    = 1'b1;
                        r.coin_type    = t;
                        r.coin_cents   = type_cents(t);
                        r.pulse_total  = pulse_count;
                        r.type_count   = type_counts[t];
                        pulse_count    = '0;
                        elapsed        = '0;
                        coin_active    = 1'b0;
                    end else begin
                        elapsed = next_elapsed[cpdc_pkg::END_W-1:0];
                    end
                end
            end
            cpdc_pkg::KIND_PULSE: begin
                if (!coin_active || elapsed >= cpdc_pkg::END_W'(debounce_ticks)) begin
                    if (pulse_count != '1) pulse_count = pulse_count + 1'b1;
                    elapsed     = '0;
                    coin_active = 1'b1;
                end
            end
            cpdc_pkg::KIND_CLEAR: begin
                foreach (type_counts[i]) type_counts[i] = '0;
                money_sum = '0;
            end
            default: begin
                if (tidx < cpdc_pkg::COIN_TYPES_DEF) r.type_count = type_counts[tidx];
            end
        endcase
        r.money_total = money_sum;
        expected_results.push_back(r);
    endfunction

    function void compare_field(input string name, input logic [cpdc_pkg::COUNT_W-1:0] want,
                                input logic [cpdc_pkg::COUNT_W-1:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            failures++;
        end
    endfunction

    function void check_result(input t_coin_result got);
        t_coin_result want;
        if (expected_results.size() == 0) begin
            $error("result transaction with no item pending");
            failures++;
            return;
        end
        want = expected_results.pop_front();
        checked++;
        compare_field("coin_done", want.coin_done, got.coin_done);
        compare_field("coin_type", want.coin_type, got.coin_type);
        compare_field("coin_cents", want.coin_cents, got.coin_cents);
        compare_field("pulse_total", want.pulse_total, got.pulse_total);
        compare_field("type_count", want.type_count, got.type_count);
        compare_field("money_total", want.money_total, got.money_total);
    endfunction
endclass

module tb_coin_pulse_decoder_counter_top;
    localparam int ITEM_GOAL = 900;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_valid = 1'b0;
    logic                            o_stall;
    logic [1:0]                      i_kind = cpdc_pkg::KIND_TICK;
    logic [cpdc_pkg::TYPE_W-1:0]     i_type_index = '0;
    logic                            o_valid;
    logic                            i_stall = 1'b0;
    logic                            o_coin_done;
    logic [cpdc_pkg::TYPE_W-1:0]     o_coin_type;
    logic [cpdc_pkg::CENTS_W-1:0]    o_coin_cents;
    logic [cpdc_pkg::PULSE_W-1:0]    o_pulse_total;
    logic [cpdc_pkg::COUNT_W-1:0]    o_type_count;
    logic [cpdc_pkg::COUNT_W-1:0]    o_money_total;
    logic                            i_cfg_valid = 1'b0;
    logic                            o_cfg_ready;
    logic [cpdc_pkg::CFG_IDX_W-1:0]  i_cfg_index = cpdc_pkg::CFG_P200;
    logic [cpdc_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;

    coin_tally_scoreboard            tally = new();
    int                              items_sent = 0;
    int                              no_gap_left = 0;
    int                              cur_debounce;
    int                              cur_end;
    logic [cpdc_pkg::PULSE_W-1:0]    cur_pulses[cpdc_pkg::NUM_MATCH];
    bit                              long_hold_done = 1'b0;

    coin_pulse_decoder_counter_top dut (.*);

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic int pick_wait();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) return $urandom_range(0, 2);
        if (roll < 95) return $urandom_range(3, 10);
        return $urandom_range(20, 50);
    endfunction

    function automatic logic [cpdc_pkg::TYPE_W-1:0] rand_index();
        return cpdc_pkg::TYPE_W'($urandom_range(0, 7));
    endfunction

    function automatic int pick_pulses();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) return cur_pulses[$urandom_range(0, cpdc_pkg::NUM_MATCH - 1)];
        if (roll < 95) return $urandom_range(1, 9);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_item(input cpdc_pkg::t_kind kind,
                             input logic [cpdc_pkg::TYPE_W-1:0] tidx);
        int gap;
        if (no_gap_left > 0) begin
            no_gap_left--;
            gap = 0;
        end else if ($urandom_range(0, 19) == 0) begin
            no_gap_left = 40;
            gap = 0;
        end else begin
            gap = pick_wait();
        end
        repeat (gap) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_valid      <= 1'b1;
        i_kind       <= kind;
        i_type_index <= tidx;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        tally.note_item(kind, tidx);
        items_sent++;
    endtask

    task automatic send_ticks(input int n);
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 7) == 0) send_item(cpdc_pkg::KIND_READ, rand_index());
            send_item(cpdc_pkg::KIND_TICK, rand_index());
        end
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (tally.expected_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input cpdc_pkg::t_cfg_idx idx,
                             input logic [cpdc_pkg::CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        tally.set_reg(idx, data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic apply_setting();
        for (int i = 0; i < cpdc_pkg::NUM_MATCH; i++) begin
            write_reg(cpdc_pkg::t_cfg_idx'(i), cpdc_pkg::CFG_DATA_W'(cur_pulses[i]));
        end
        write_reg(cpdc_pkg::CFG_DEBOUNCE, cpdc_pkg::CFG_DATA_W'(cur_debounce));
        write_reg(cpdc_pkg::CFG_END, cpdc_pkg::CFG_DATA_W'(cur_end));
    endtask

    task automatic random_setting();
        foreach (cur_pulses[i]) begin
            cur_pulses[i] = ($urandom_range(0, 9) < 7)
                          ? cpdc_pkg::PULSE_W'($urandom_range(1, 8))
                          : cpdc_pkg::PULSE_W'($urandom_range(1, 63));
        end
        cur_debounce = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 12) : $urandom_range(0, 3);
        cur_end      = $urandom_range(1, 8);
        apply_setting();
    endtask

    // clean coins keep every pulse outside the debounce window
    task automatic run_coin(input int pulses, input bit clean);
        int spacing;
        for (int k = 0; k < pulses; k++) begin
            send_item(cpdc_pkg::KIND_PULSE, rand_index());
            if (k == pulses - 1) break;
            if (clean) spacing = cur_debounce + $urandom_range(0, 2);
            else spacing = $urandom_range(0, cur_debounce + 1);
            if (!clean && $urandom_range(0, 2) == 0) begin
                send_ticks(spacing / 2);
                send_item(cpdc_pkg::KIND_PULSE, rand_index());
                send_ticks(spacing - spacing / 2);
            end else begin
                send_ticks(spacing);
            end
        end
        if (!clean && $urandom_range(0, 2) == 0) begin
            send_ticks($urandom_range(0, cur_end));
            send_item(cpdc_pkg::KIND_PULSE, rand_index());
        end
        send_ticks(cur_end + 1 + (clean ? 0 : $urandom_range(0, 3)));
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            tally.check_result({o_coin_done, o_coin_type, o_coin_cents, o_pulse_total,
                                o_type_count, o_money_total});
        end
    end

    initial begin
        int stall_left;
        int free_left;
        stall_left = 0;
        free_left  = 0;
        forever begin
            @(negedge i_clk);
            // one long hold so the pipeline fills and backs up
            if (!long_hold_done && tally.checked >= 300) begin
                long_hold_done = 1'b1;
                stall_left = 120;
            end
            if (stall_left > 0) begin
                stall_left--;
                i_stall <= 1'b1;
            end else if (free_left > 0) begin
                free_left--;
                i_stall <= 1'b0;
            end else begin
                free_left  = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80)
                                                         : $urandom_range(0, 6);
                stall_left = pick_wait();
                i_stall <= 1'b0;
            end
        end
    end

    initial begin
        int phase_goal;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        cur_pulses   = '{6'd63, 6'd2, 6'd2, 6'd4, 6'd5, 6'd6};
        cur_debounce = 2;
        cur_end      = 3;
        apply_setting();
        for (int t = 0; t < 8; t++) send_item(cpdc_pkg::KIND_READ, cpdc_pkg::TYPE_W'(t));
        send_item(cpdc_pkg::KIND_TICK, cpdc_pkg::TYPE_UNKNOWN);
        send_item(cpdc_pkg::KIND_PULSE, cpdc_pkg::TYPE_200);
        send_item(cpdc_pkg::KIND_PULSE, cpdc_pkg::TYPE_200);
        repeat (2) send_item(cpdc_pkg::KIND_TICK, cpdc_pkg::TYPE_200);
        send_item(cpdc_pkg::KIND_PULSE, cpdc_pkg::TYPE_100);
        repeat (4) send_item(cpdc_pkg::KIND_TICK, cpdc_pkg::TYPE_100);
        send_item(cpdc_pkg::KIND_READ, cpdc_pkg::TYPE_100);
        send_item(cpdc_pkg::KIND_PULSE, cpdc_pkg::TYPE_5);
        repeat (4) send_item(cpdc_pkg::KIND_TICK, cpdc_pkg::TYPE_5);
        send_item(cpdc_pkg::KIND_READ, cpdc_pkg::TYPE_UNKNOWN);
        send_item(cpdc_pkg::KIND_CLEAR, cpdc_pkg::TYPE_UNKNOWN);
        send_item(cpdc_pkg::KIND_READ, cpdc_pkg::TYPE_100);
        drain();

        // widest debounce and end windows
        cur_pulses   = '{6'd63, 6'd62, 6'd1, 6'd1, 6'd1, 6'd1};
        cur_debounce = 1023;
        cur_end      = 4095;
        apply_setting();
        send_item(cpdc_pkg::KIND_PULSE, cpdc_pkg::TYPE_200);
        send_ticks(6);
        send_item(cpdc_pkg::KIND_PULSE, cpdc_pkg::TYPE_200);
        send_ticks(6);
        drain();
        // shrink the end window under an open coin
        cur_end = 3;
        write_reg(cpdc_pkg::CFG_END, cpdc_pkg::CFG_DATA_W'(cur_end));
        send_ticks(2);
        drain();

        // no debounce, pulse count saturation
        cur_pulses   = '{6'd63, 6'd1, 6'd2, 6'd3, 6'd4, 6'd5};
        cur_debounce = 0;
        cur_end      = 1;
        apply_setting();
        run_coin(70, 1'b1);
        run_coin(63, 1'b1);
        run_coin(62, 1'b0);
        drain();

        while (items_sent < ITEM_GOAL) begin
            random_setting();
            phase_goal = items_sent + $urandom_range(60, 160);
            while (items_sent < phase_goal) begin
                if ($urandom_range(0, 4) == 0) begin
                    repeat ($urandom_range(1, 4)) begin
                        send_item(cpdc_pkg::t_kind'($urandom_range(0, 3)), rand_index());
                    end
                end
                run_coin(pick_pulses(), $urandom_range(0, 3) != 0);
                if ($urandom_range(0, 7) == 0) drain();
            end
            drain();
        end

        cur_pulses   = '{default: 6'd1};
        cur_debounce = 0;
        cur_end      = 1;
        apply_setting();
        repeat (5) run_coin($urandom_range(1, 3), 1'b0);
        drain();
        repeat (10) @(posedge i_clk);

        if (tally.failures == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #100_000_000;
        $display("Verification failed");
        $finish;
    end
endmodule
